/* rtl/assert_macros.svh */
// Assertion macros used by the checker of this block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* rtl/txdra_pkg.sv */
// Shared types, codes and field widths of the transmit ring credit allocator.
// Depends on nothing; used by the core and the checker.
package txdra_pkg;

   // Field and register widths.
   localparam int LEN_W       = 16;
   localparam int PORT_W      = 3;
   localparam int HOST_W      = 64;
   localparam int WORD_W      = 64;
   localparam int STATUS_W    = 3;
   localparam int SLOT_IDX_W  = 8;
   localparam int LINES_W     = 11;
   localparam int DESC_LIM_W  = 9;
   localparam int LINE_LIM_W  = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int LOW_WORD_W  = 32;
   localparam int ALIGN_BITS  = 6;
   localparam int LINE_SHIFT  = 6;

   // Largest values the limit registers can hold.
   localparam int DESC_LIM_MAX = 511;
   localparam int LINE_LIM_MAX = 8191;

   // Default ring sizes.
   localparam int DEF_DESC_SLOTS = 256;
   localparam int DEF_BUF_LINES  = 4096;

   // Packet length handling.
   localparam logic [LEN_W-1:0] MIN_FRAME   = 16'd60;
   localparam int               ALIGN_SLACK = 2 * 63;

   // Reset values of the limit registers.
   localparam logic [DESC_LIM_W-1:0] DESC_LIMIT_RST = 9'd256;
   localparam logic [LINE_LIM_W-1:0] LINE_LIMIT_RST = 13'd4096;

   typedef enum logic {
      OP_SUBMIT  = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACCEPTED = 3'd0,
      ST_TOO_BIG  = 3'd1,
      ST_BUSY     = 3'd2,
      ST_RELEASED = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DESC_LIMIT = 2'd0,
      CSR_LINE_LIMIT = 2'd1
   } csr_index_type;

endpackage

/* rtl/tx_dma_ring_credit_allocator_core.sv */
// Top level of the transmit DMA descriptor ring and buffer-line credit allocator.
// Depends on txdra_pkg and txdra_slot_ram.
//
// Usage:
//   Input items arrive on req_* and are taken at a rising edge with start high
//   and busy low. A submit item (operation 0) asks for a descriptor slot and
//   (pkt_len + 126) / 64 buffer lines; a release item (operation 1) frees the
//   oldest outstanding descriptor and its lines.
//   Every item gives exactly one result on rsp_*, shown for one cycle with
//   rsp_strobe high, in the cycle right after the item was taken.
//   No new item is taken while a result is shown: busy stays high for the cycle
//   in which the result is shown, because a release needs the line count that
//   the slot memory returns in the cycle after its read address is issued.
//   The limit registers are written through csr_* at an edge with csr_write_en
//   high; the user must write them only while the block is idle, which is not enforced.
//   Synchronous reset clears the pointers, the counters and the in-flight item
//   and returns the limits to 256 descriptors and 4096 lines. The line-count
//   memory is not cleared; only slots written by an accepted submit are read.
//   The receiver cannot stall: each result must be taken in its cycle.
module tx_dma_ring_credit_allocator_core #(
   parameter int DESC_SLOTS = txdra_pkg::DEF_DESC_SLOTS,
   parameter int BUF_LINES  = txdra_pkg::DEF_BUF_LINES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_operation,
   input  logic [txdra_pkg::LEN_W-1:0]        req_pkt_len,
   input  logic [txdra_pkg::PORT_W-1:0]       req_src_port,
   input  logic [txdra_pkg::HOST_W-1:0]       req_host_addr,
   output logic                               rsp_strobe,
   output logic [txdra_pkg::STATUS_W-1:0]     rsp_status,
   output logic [txdra_pkg::SLOT_IDX_W-1:0]   rsp_slot_index,
   output logic [txdra_pkg::WORD_W-1:0]       rsp_word_zero,
   output logic [txdra_pkg::WORD_W-1:0]       rsp_word_one,
   output logic                               rsp_stop_flag,
   output logic                               rsp_wake_flag,
   input  logic                               csr_write_en,
   input  logic [txdra_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [txdra_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import txdra_pkg::*;

   localparam int SLOT_W     = $clog2(DESC_SLOTS);
   localparam int LINE_PTR_W = $clog2(BUF_LINES);
   localparam int OFS_SUM_W  = ((LINE_PTR_W > LINES_W) ? LINE_PTR_W : LINES_W) + 1;
   localparam int LEN_SUM_W  = LEN_W + 1;

   // Effective limits never exceed the ring sizes.
   localparam logic [DESC_LIM_W-1:0] DESC_CAP =
      DESC_LIM_W'((DESC_SLOTS < DESC_LIM_MAX) ? DESC_SLOTS : DESC_LIM_MAX);
   localparam logic [LINE_LIM_W-1:0] LINE_CAP =
      LINE_LIM_W'((BUF_LINES < LINE_LIM_MAX) ? BUF_LINES : LINE_LIM_MAX);
   localparam logic [SLOT_W-1:0]     SLOT_LAST  = SLOT_W'(DESC_SLOTS - 1);
   localparam logic [OFS_SUM_W-1:0]  BUF_WRAP   = OFS_SUM_W'(BUF_LINES);

   // Configuration registers.
   logic [DESC_LIM_W-1:0] desc_limit_ff;
   logic [LINE_LIM_W-1:0] line_limit_ff;

   // Ring state.
   logic [LINE_PTR_W-1:0] buf_line_ptr_ff, buf_line_ptr_in;
   logic [SLOT_W-1:0]     slot_write_ptr_ff, slot_write_ptr_in;
   logic [SLOT_W-1:0]     slot_release_ptr_ff, slot_release_ptr_in;
   logic [DESC_LIM_W-1:0] slots_in_use_ff, slots_in_use_in;
   logic [LINE_LIM_W-1:0] lines_in_use_ff, lines_in_use_in;

   // Item in flight: taken at the previous edge, resolved this cycle.
   logic                  stage_valid_ff;
   logic                  op_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [PORT_W-1:0]     port_ff;
   logic [HOST_W-1:0]     host_ff;

   logic                  accept;
   logic [LINES_W-1:0]    freed_lines;

   // Resolution of the item in flight.
   logic [LEN_SUM_W-1:0]  len_sum;
   logic [LINES_W-1:0]    lines_needed;
   logic [DESC_LIM_W-1:0] desc_lim;
   logic [LINE_LIM_W-1:0] line_lim;
   logic                  is_release;
   logic                  too_big;
   logic                  no_room;
   logic                  ring_empty;
   logic                  do_submit;
   logic                  do_release;
   logic [LEN_W-1:0]      padded_len;
   logic [OFS_SUM_W-1:0]  ofs_sum;
   logic [LINE_LIM_W-1:0] freed_ext;

   assign accept = start && !busy;
   assign busy   = stage_valid_ff;

   // Limit registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         desc_limit_ff <= DESC_LIMIT_RST;
         line_limit_ff <= LINE_LIMIT_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_DESC_LIMIT: desc_limit_ff <= csr_wdata[DESC_LIM_W-1:0];
            CSR_LINE_LIMIT: line_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Capture the item; the release pointer is read from memory at the same edge.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_operation;
         len_ff  <= req_pkt_len;
         port_ff <= req_src_port;
         host_ff <= req_host_addr;
      end
   end

   // Per-slot line counts, written on an accepted submit.
   txdra_slot_ram #(
      .DEPTH  (DESC_SLOTS),
      .ADDR_W (SLOT_W),
      .DATA_W (LINES_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (do_submit),
      .wr_addr (slot_write_ptr_ff),
      .wr_data (lines_needed),
      .rd_en   (accept),
      .rd_addr (slot_release_ptr_ff),
      .rd_data (freed_lines)
   );

   // Decide the item in flight.
   always_comb begin
      is_release   = (op_ff == OP_RELEASE);
      len_sum      = {1'b0, len_ff} + LEN_SUM_W'(ALIGN_SLACK);
      lines_needed = len_sum[LEN_SUM_W-1:LINE_SHIFT];
      desc_lim     = (desc_limit_ff > DESC_CAP) ? DESC_CAP : desc_limit_ff;
      line_lim     = (line_limit_ff > LINE_CAP) ? LINE_CAP : line_limit_ff;
      too_big      = LINE_LIM_W'(lines_needed) > line_lim;
      no_room      = (({1'b0, slots_in_use_ff} + (DESC_LIM_W + 1)'(1)) > {1'b0, desc_lim})
                  || (({1'b0, lines_in_use_ff} + (LINE_LIM_W + 1)'(lines_needed))
                      > {1'b0, line_lim});
      ring_empty   = (slots_in_use_ff == '0);
      do_submit    = stage_valid_ff && !is_release && !too_big && !no_room;
      do_release   = stage_valid_ff && is_release && !ring_empty;
      padded_len   = (len_ff < MIN_FRAME) ? MIN_FRAME : len_ff;
      ofs_sum      = OFS_SUM_W'(buf_line_ptr_ff) + OFS_SUM_W'(lines_needed);
      freed_ext    = LINE_LIM_W'(freed_lines);
   end

   // Next ring state.
   always_comb begin
      buf_line_ptr_in     = buf_line_ptr_ff;
      slot_write_ptr_in   = slot_write_ptr_ff;
      slot_release_ptr_in = slot_release_ptr_ff;
      slots_in_use_in     = slots_in_use_ff;
      lines_in_use_in     = lines_in_use_ff;
      if (do_submit) begin
         // The sum stays below twice the buffer size, so one subtract wraps it.
         buf_line_ptr_in   = (ofs_sum >= BUF_WRAP) ? LINE_PTR_W'(ofs_sum - BUF_WRAP)
                                                   : LINE_PTR_W'(ofs_sum);
         slot_write_ptr_in = (slot_write_ptr_ff == SLOT_LAST) ? '0
                                                              : slot_write_ptr_ff + 1'b1;
         slots_in_use_in   = slots_in_use_ff + 1'b1;
         lines_in_use_in   = lines_in_use_ff + LINE_LIM_W'(lines_needed);
      end else if (do_release) begin
         slot_release_ptr_in = (slot_release_ptr_ff == SLOT_LAST) ? '0
                                                                  : slot_release_ptr_ff + 1'b1;
         slots_in_use_in     = slots_in_use_ff - 1'b1;
         lines_in_use_in     = (freed_ext > lines_in_use_ff) ? '0
                                                             : lines_in_use_ff - freed_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_line_ptr_ff     <= '0;
         slot_write_ptr_ff   <= '0;
         slot_release_ptr_ff <= '0;
         slots_in_use_ff     <= '0;
         lines_in_use_ff     <= '0;
      end else begin
         buf_line_ptr_ff     <= buf_line_ptr_in;
         slot_write_ptr_ff   <= slot_write_ptr_in;
         slot_release_ptr_ff <= slot_release_ptr_in;
         slots_in_use_ff     <= slots_in_use_in;
         lines_in_use_ff     <= lines_in_use_in;
      end
   end

   // Result fields; unused fields stay zero.
   always_comb begin
      rsp_strobe     = stage_valid_ff;
      rsp_status     = ST_ACCEPTED;
      rsp_slot_index = '0;
      rsp_word_zero  = '0;
      rsp_word_one   = '0;
      rsp_stop_flag  = 1'b0;
      rsp_wake_flag  = 1'b0;
      if (is_release) begin
         if (ring_empty) begin
            rsp_status = ST_EMPTY;
         end else begin
            rsp_status     = ST_RELEASED;
            rsp_slot_index = SLOT_IDX_W'(slot_release_ptr_ff);
            rsp_wake_flag  = 1'b1;
         end
      end else if (too_big) begin
         rsp_status = ST_TOO_BIG;
      end else if (no_room) begin
         rsp_status    = ST_BUSY;
         rsp_stop_flag = !ring_empty;
      end else begin
         // The buffer offset is a whole number of lines, so the alignment
         // bits of the host address fill its low bits.
         rsp_status     = ST_ACCEPTED;
         rsp_slot_index = SLOT_IDX_W'(slot_write_ptr_ff);
         rsp_word_zero  = {padded_len, (WORD_W - LEN_W - PORT_W - LOW_WORD_W)'(0), port_ff,
                           LOW_WORD_W'({buf_line_ptr_ff, host_ff[ALIGN_BITS-1:0]})};
         rsp_word_one   = host_ff;
      end
   end

endmodule

/* rtl/txdra_slot_ram.sv */
// Line-count memory: one entry per descriptor slot, one write and one read port.
// Depends on nothing; the read data is registered, so it arrives in the cycle after the read.
module txdra_slot_ram #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8,
   parameter int DATA_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/txdra_checker.sv */
// Port-level checks of the allocator core, attached by the bind at the end.
// Depends on txdra_pkg and assert_macros.svh.
`include "assert_macros.svh"

module txdra_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_strobe,
   input logic [txdra_pkg::STATUS_W-1:0]     rsp_status,
   input logic [txdra_pkg::SLOT_IDX_W-1:0]   rsp_slot_index,
   input logic [txdra_pkg::WORD_W-1:0]       rsp_word_zero,
   input logic [txdra_pkg::WORD_W-1:0]       rsp_word_one,
   input logic                               rsp_stop_flag,
   input logic                               rsp_wake_flag
);

   import txdra_pkg::*;

   logic taken;
   logic rsp_unused_zero;

   assign taken           = start && !busy;
   assign rsp_unused_zero = (rsp_slot_index == '0) && (rsp_word_zero == '0)
                         && (rsp_word_one == '0);

   // Every item taken gives its result in the next cycle.
   `ASSERT_NEXT(a_result_follows, clock, reset, taken, rsp_strobe)

   // A result is shown only while the block holds off new items.
   `ASSERT_IMPLY(a_result_busy, clock, reset, rsp_strobe, busy)

   // Stop is raised only on a busy answer, wake only on a release.
   `ASSERT_IMPLY(a_stop_only_busy, clock, reset, rsp_strobe && rsp_stop_flag,
                 rsp_status == ST_BUSY)
   `ASSERT_IMPLY(a_wake_only_release, clock, reset, rsp_strobe && rsp_wake_flag,
                 rsp_status == ST_RELEASED)

   // Refused and empty answers carry no slot and no descriptor words.
   `ASSERT_IMPLY(a_refusal_clean, clock, reset,
                 rsp_strobe && (rsp_status == ST_TOO_BIG || rsp_status == ST_BUSY
                                || rsp_status == ST_EMPTY),
                 rsp_unused_zero)

endmodule

bind tx_dma_ring_credit_allocator_core txdra_checker u_txdra_checker (.*);
